// File: design/sbc_pkg.sv
package sbc_pkg;

    // Fixed-point layout of the normal and the root search
    localparam int FRAC_BITS   = 16;
    localparam int NORM_BITS   = 18;
    localparam int K_BITS      = 17;
    localparam int REDUCE_BITS = 24;
    localparam int W_BITS      = 24;
    localparam int WSQ_W       = 48;
    localparam int SSQ_W       = 50;
    localparam int ROOT_BITS   = 18;
    localparam int Q_W         = 68;
    localparam int REM_W       = 88;
    localparam int TGT_SHIFT   = 34;

    typedef logic [REM_W-1:0]     rem_t;
    typedef logic [Q_W-1:0]       qacc_t;
    typedef logic [SSQ_W-1:0]     ssq_t;
    typedef logic [ROOT_BITS-1:0] root_t;

    // Handshake between pipeline sections
    typedef struct packed {
        logic valid;
    } sbc_fwd_t;

endpackage

// File: design/sbc_geom.sv
module sbc_geom #(
    parameter int COORD_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sbc_pkg::sbc_fwd_t                    in_fwd,
    output logic                                 in_ready,
    input  logic [2:0][COORD_BITS-1:0]           ctr_in,
    input  logic [COORD_BITS-2:0]                rad_in,
    input  logic [2:0][COORD_BITS-1:0]           bc_in,
    input  logic [2:0][COORD_BITS-2:0]           half_in,
    output sbc_pkg::sbc_fwd_t                    out_fwd,
    input  logic                                 out_ready,
    output sbc_pkg::rem_t [2:0]                  rem_out,
    output sbc_pkg::ssq_t                        ssq_out,
    output logic [7*COORD_BITS+2:0]              side_out
);
    import sbc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int AV_W   = CB + 1;
    localparam int SH_W   = $clog2(AV_W + 1);
    localparam int SIDE_W = 7 * CB + 3;
    localparam int NST    = 6;

    logic [NST-1:0] v_reg, v_next;
    logic [NST:0]   rdy;

    // stage 1: input words
    logic [2:0][CB-1:0] a_ctr_reg, a_bc_reg;
    logic [2:0][CB-2:0] a_half_reg;
    logic [CB-2:0]      a_rad_reg;

    // stage 2: clamp
    logic signed [CB:0] lo [3];
    logic signed [CB:0] hi [3];
    logic signed [CB:0] ce [3];
    logic signed [CB:0] cpw [3];
    logic signed [CB:0] dw [3];
    logic [2:0]         below;
    logic [2:0]         eq;
    logic [2:0][CB-1:0] b_cp_reg, b_d_reg, b_ctr_reg;
    logic [2:0][CB:0]   b_cv_reg;
    logic [2:0]         b_dneg_reg;
    logic               b_inside_reg;
    logic [CB-2:0]      b_rad_reg;

    // stage 3: squares, direction magnitude
    logic [2:0][AV_W-1:0]   av;
    logic [2:0]             sgn;
    logic [2:0][2*CB-1:0]   c_dsq_reg;
    logic [2*CB-3:0]        c_radsq_reg;
    logic [2:0][AV_W-1:0]   c_av_reg;
    logic [SIDE_W-2:0]      c_side_reg;

    // stage 4: hit test, reduction shift
    logic [2*CB+1:0]        dsum;
    logic [AV_W-1:0]        mx;
    logic [SH_W-1:0]        len;
    logic [SH_W-1:0]        sh;
    logic [SH_W-1:0]        d_sh_reg;
    logic [2:0][AV_W-1:0]   d_av_reg;
    logic [SIDE_W-1:0]      d_side_reg;

    // stage 5: reduced components squared
    logic [2:0][AV_W-1:0]   sft;
    logic [2:0][W_BITS-1:0] w;
    logic [2:0][WSQ_W-1:0]  e_wsq_reg;
    logic [SIDE_W-1:0]      e_side_reg;

    // stage 6: sum of squares and root targets
    rem_t [2:0]             f_rem_reg;
    ssq_t                   f_ssq_reg;
    logic [SIDE_W-1:0]      f_side_reg;

    // advance valid bits; a stage loads when empty or its word moves on
    always_comb begin
        rdy[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next[0] = rdy[0] ? in_fwd.valid : v_reg[0];
        for (int i = 1; i < NST; i++) begin
            v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign in_ready      = rdy[0];
    assign out_fwd.valid = v_reg[NST-1];

    // clamp center into the box
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ce[i]    = $signed({a_ctr_reg[i][CB-1], a_ctr_reg[i]});
            lo[i]    = $signed({a_bc_reg[i][CB-1], a_bc_reg[i]}) - $signed({2'b00, a_half_reg[i]});
            hi[i]    = $signed({a_bc_reg[i][CB-1], a_bc_reg[i]}) + $signed({2'b00, a_half_reg[i]});
            below[i] = ce[i] < lo[i];
            if (below[i]) begin
                cpw[i] = lo[i];
                dw[i]  = lo[i] - ce[i];
            end else if (ce[i] > hi[i]) begin
                cpw[i] = hi[i];
                dw[i]  = ce[i] - hi[i];
            end else begin
                cpw[i] = ce[i];
                dw[i]  = '0;
            end
            eq[i] = cpw[i] == ce[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a_ctr_reg  <= ctr_in;
            a_bc_reg   <= bc_in;
            a_half_reg <= half_in;
            a_rad_reg  <= rad_in;
        end
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                b_cp_reg[i] <= cpw[i][CB-1:0];
                b_d_reg[i]  <= dw[i][CB-1:0];
                b_cv_reg[i] <= ce[i] - $signed({a_bc_reg[i][CB-1], a_bc_reg[i]});
            end
            b_dneg_reg   <= below;
            b_inside_reg <= &eq;
            b_ctr_reg    <= a_ctr_reg;
            b_rad_reg    <= a_rad_reg;
        end
    end

    // pick the direction: box center when inside, closest point otherwise
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (b_inside_reg) begin
                av[i]  = b_cv_reg[i][CB] ? AV_W'(-b_cv_reg[i]) : b_cv_reg[i];
                sgn[i] = b_cv_reg[i][CB];
            end else begin
                av[i]  = {1'b0, b_d_reg[i]};
                sgn[i] = b_dneg_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                c_dsq_reg[i] <= b_d_reg[i] * b_d_reg[i];
            end
            c_radsq_reg <= b_rad_reg * b_rad_reg;
            c_av_reg    <= av;
            c_side_reg  <= {sgn, b_cp_reg, b_rad_reg, b_ctr_reg};
        end
    end

    // squared distance against squared radius; leading one of the largest component
    always_comb begin
        dsum = (2*CB+2)'(c_dsq_reg[0]) + (2*CB+2)'(c_dsq_reg[1]) + (2*CB+2)'(c_dsq_reg[2]);
        mx = c_av_reg[0];
        if (c_av_reg[1] > mx) mx = c_av_reg[1];
        if (c_av_reg[2] > mx) mx = c_av_reg[2];
        len = '0;
        for (int i = 0; i < AV_W; i++) begin
            if (mx[i]) len = SH_W'(i + 1);
        end
        sh = (len > SH_W'(REDUCE_BITS)) ? len - SH_W'(REDUCE_BITS) : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            d_side_reg <= {dsum <= (2*CB+2)'(c_radsq_reg), c_side_reg};
            d_sh_reg   <= sh;
            d_av_reg   <= c_av_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sft[i] = d_av_reg[i] >> d_sh_reg;
            w[i]   = W_BITS'(sft[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            for (int i = 0; i < 3; i++) begin
                e_wsq_reg[i] <= w[i] * w[i];
            end
            e_side_reg <= d_side_reg;
        end
        if (rdy[5]) begin
            for (int i = 0; i < 3; i++) begin
                f_rem_reg[i] <= REM_W'(e_wsq_reg[i]) << TGT_SHIFT;
            end
            f_ssq_reg  <= SSQ_W'(e_wsq_reg[0]) + SSQ_W'(e_wsq_reg[1]) + SSQ_W'(e_wsq_reg[2]);
            f_side_reg <= e_side_reg;
        end
    end

    assign rem_out  = f_rem_reg;
    assign ssq_out  = f_ssq_reg;
    assign side_out = f_side_reg;

endmodule

// File: design/sbc_root_step.sv
module sbc_root_step #(
    parameter int BIT    = 0,
    parameter int SIDE_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbc_pkg::sbc_fwd_t     in_fwd,
    output logic                  in_ready,
    input  sbc_pkg::rem_t [2:0]   rem_in,
    input  sbc_pkg::qacc_t [2:0]  qacc_in,
    input  sbc_pkg::root_t [2:0]  root_in,
    input  sbc_pkg::ssq_t         ssq_in,
    input  logic [SIDE_W-1:0]     side_in,
    output sbc_pkg::sbc_fwd_t     out_fwd,
    input  logic                  out_ready,
    output sbc_pkg::rem_t [2:0]   rem_out,
    output sbc_pkg::qacc_t [2:0]  qacc_out,
    output sbc_pkg::root_t [2:0]  root_out,
    output sbc_pkg::ssq_t         ssq_out,
    output logic [SIDE_W-1:0]     side_out
);
    import sbc_pkg::*;

    logic          v_reg, v_next;
    rem_t [2:0]    dlt;
    logic [2:0]    take;
    rem_t [2:0]    rem_reg;
    qacc_t [2:0]   qacc_reg;
    root_t [2:0]   root_reg;
    ssq_t          ssq_reg;
    logic [SIDE_W-1:0] side_reg;

    assign in_ready = !v_reg || out_ready;
    assign v_next   = in_ready ? in_fwd.valid : v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
        end
    end

    // try this root bit: (x + 2^b)^2 * ssq - x^2 * ssq against the remainder
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dlt[i]  = (REM_W'(qacc_in[i]) << (BIT + 1)) + (REM_W'(ssq_in) << (2 * BIT));
            take[i] = dlt[i] <= rem_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            for (int i = 0; i < 3; i++) begin
                if (take[i]) begin
                    rem_reg[i]  <= rem_in[i] - dlt[i];
                    qacc_reg[i] <= qacc_in[i] + (Q_W'(ssq_in) << BIT);
                    root_reg[i] <= root_in[i] | (ROOT_BITS'(1) << BIT);
                end else begin
                    rem_reg[i]  <= rem_in[i];
                    qacc_reg[i] <= qacc_in[i];
                    root_reg[i] <= root_in[i];
                end
            end
            ssq_reg  <= ssq_in;
            side_reg <= side_in;
        end
    end

    assign out_fwd.valid = v_reg;
    assign rem_out       = rem_reg;
    assign qacc_out      = qacc_reg;
    assign root_out      = root_reg;
    assign ssq_out       = ssq_reg;
    assign side_out      = side_reg;

endmodule

// File: design/sbc_contact.sv
module sbc_contact #(
    parameter int COORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbc_pkg::sbc_fwd_t             in_fwd,
    output logic                          in_ready,
    input  sbc_pkg::root_t [2:0]          root_in,
    input  sbc_pkg::ssq_t                 ssq_in,
    input  logic [7*COORD_BITS+2:0]       side_in,
    output sbc_pkg::sbc_fwd_t             out_fwd,
    input  logic                          out_ready,
    output logic                          hit_out,
    output logic [2:0][17:0]              nrm_out,
    output logic [2:0][COORD_BITS-1:0]    sp_out,
    output logic [2:0][COORD_BITS-1:0]    bp_out
);
    import sbc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int SIDE_W = 7 * CB + 3;
    localparam int P_W    = K_BITS + CB - 1;
    localparam int OFF_W  = CB + 1;
    localparam int CP_LO  = 4 * CB - 1;
    localparam int SG_LO  = 7 * CB - 1;

    logic [1:0] v_reg, v_next;
    logic [2:0] rdy;

    logic [CB-2:0]              rad;
    logic                       zero;
    logic [2:0][ROOT_BITS:0]    rp1;
    logic [2:0][K_BITS-1:0]     k;
    logic [2:0][K_BITS-1:0]     g_k_reg;
    logic [2:0][P_W-1:0]        g_p_reg;
    logic [SIDE_W-1:0]          g_side_reg;

    logic [2:0][P_W:0]          prnd;
    logic [2:0][OFF_W-1:0]      off;
    logic signed [CB+1:0]       spw [3];
    logic [2:0][CB-1:0]         sp;
    logic [2:0][CB-1:0]         ctr;
    logic [2:0][CB-1:0]         cp;
    logic [2:0]                 sgn;
    logic                       hit;

    logic                       hit_reg;
    logic [2:0][17:0]           nrm_reg;
    logic [2:0][CB-1:0]         sp_reg, bp_reg;

    always_comb begin
        rdy[2] = out_ready;
        for (int i = 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next[0] = rdy[0] ? in_fwd.valid : v_reg[0];
        v_next[1] = rdy[1] ? v_reg[0] : v_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign in_ready      = rdy[0];
    assign out_fwd.valid = v_reg[1];

    // round the root to the normal component; drop it on a miss or zero direction
    always_comb begin
        rad  = side_in[3*CB +: CB-1];
        zero = !side_in[SIDE_W-1] || (ssq_in == '0);
        for (int i = 0; i < 3; i++) begin
            rp1[i] = {1'b0, root_in[i]} + (ROOT_BITS+1)'(1);
            k[i]   = zero ? '0 : rp1[i][K_BITS:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                g_p_reg[i] <= k[i] * rad;
            end
            g_k_reg    <= k;
            g_side_reg <= side_in;
        end
    end

    // sphere point: center minus the rounded offset along the normal's sign, saturated
    always_comb begin
        hit = g_side_reg[SIDE_W-1];
        sgn = g_side_reg[SG_LO +: 3];
        for (int i = 0; i < 3; i++) begin
            ctr[i]  = g_side_reg[i*CB +: CB];
            cp[i]   = g_side_reg[CP_LO + i*CB +: CB];
            prnd[i] = {1'b0, g_p_reg[i]} + (P_W+1)'(1 << (FRAC_BITS - 1));
            off[i]  = OFF_W'(prnd[i] >> FRAC_BITS);
            if (sgn[i]) begin
                spw[i] = $signed({{2{ctr[i][CB-1]}}, ctr[i]}) + $signed({1'b0, off[i]});
            end else begin
                spw[i] = $signed({{2{ctr[i][CB-1]}}, ctr[i]}) - $signed({1'b0, off[i]});
            end
            if (spw[i][CB+1:CB-1] == 3'b000 || spw[i][CB+1:CB-1] == 3'b111) begin
                sp[i] = spw[i][CB-1:0];
            end else if (spw[i][CB+1]) begin
                sp[i] = {1'b1, {(CB-1){1'b0}}};
            end else begin
                sp[i] = {1'b0, {(CB-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            hit_reg <= hit;
            for (int i = 0; i < 3; i++) begin
                nrm_reg[i] <= sgn[i] ? 18'(-{1'b0, g_k_reg[i]}) : {1'b0, g_k_reg[i]};
                sp_reg[i]  <= hit ? sp[i] : '0;
                bp_reg[i]  <= hit ? cp[i] : '0;
            end
        end
    end

    assign hit_out = hit_reg;
    assign nrm_out = nrm_reg;
    assign sp_out  = sp_reg;
    assign bp_out  = bp_reg;

endmodule

// File: design/sphere_box_contact_top.sv
// Channel   Dir  Word contents (low bits first)
// s_*       in   tdata: sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
//                       box_half_x, box_half_y, box_half_z
// m_*       out  tdata: normal_x/y/z, sphere_point_x/y/z, box_point_x/y/z; tuser: hit
//
// One word per cycle in and out while m_tready is high: six geometry stages, eighteen
// stages of the digit-by-digit root search (one root bit per stage, all three axes
// side by side) and two output stages. Every stage holds its word while the next is
// full, so a stall in m_tready backs up without loss and bubbles are squeezed out.
// aresetn (synchronous) clears only the valid bits.
module sphere_box_contact_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
    // box_half_x, box_half_y, box_half_z
    input  logic [((10*COORD_BITS-4+7)/8)*8-1:0]          s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // normal_x, normal_y, normal_z, sphere_point_x/y/z, box_point_x/y/z
    output logic [((6*COORD_BITS+54+7)/8)*8-1:0]          m_tdata,
    // hit
    output logic [0:0]                                    m_tuser
);
    import sbc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int SIDE_W = 7 * CB + 3;
    localparam int OUT_W  = ((6*CB + 54 + 7) / 8) * 8;

    logic [2:0][CB-1:0] ctr, bc;
    logic [2:0][CB-2:0] half;
    logic [CB-2:0]      rad;

    sbc_fwd_t             st_fwd   [ROOT_BITS+1];
    logic                 st_ready [ROOT_BITS+1];
    rem_t [2:0]           st_rem   [ROOT_BITS+1];
    qacc_t [2:0]          st_q     [ROOT_BITS+1];
    root_t [2:0]          st_root  [ROOT_BITS+1];
    ssq_t                 st_ssq   [ROOT_BITS+1];
    logic [SIDE_W-1:0]    st_side  [ROOT_BITS+1];

    sbc_fwd_t             in_fwd, out_fwd;
    logic                 hit;
    logic [2:0][17:0]     nrm;
    logic [2:0][CB-1:0]   sp, bp;

    // unpack the input word
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ctr[i]  = s_tdata[i*CB +: CB];
            bc[i]   = s_tdata[4*CB - 1 + i*CB +: CB];
            half[i] = s_tdata[7*CB - 1 + i*(CB-1) +: CB-1];
        end
        rad = s_tdata[3*CB +: CB-1];
    end

    assign in_fwd.valid = s_tvalid;

    sbc_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fwd    (in_fwd),
        .in_ready  (s_tready),
        .ctr_in    (ctr),
        .rad_in    (rad),
        .bc_in     (bc),
        .half_in   (half),
        .out_fwd   (st_fwd[0]),
        .out_ready (st_ready[0]),
        .rem_out   (st_rem[0]),
        .ssq_out   (st_ssq[0]),
        .side_out  (st_side[0])
    );

    assign st_q[0]    = '0;
    assign st_root[0] = '0;

    // root bits from the top down, one per stage
    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
        sbc_root_step #(.BIT(ROOT_BITS - 1 - j), .SIDE_W(SIDE_W)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_fwd    (st_fwd[j]),
            .in_ready  (st_ready[j]),
            .rem_in    (st_rem[j]),
            .qacc_in   (st_q[j]),
            .root_in   (st_root[j]),
            .ssq_in    (st_ssq[j]),
            .side_in   (st_side[j]),
            .out_fwd   (st_fwd[j+1]),
            .out_ready (st_ready[j+1]),
            .rem_out   (st_rem[j+1]),
            .qacc_out  (st_q[j+1]),
            .root_out  (st_root[j+1]),
            .ssq_out   (st_ssq[j+1]),
            .side_out  (st_side[j+1])
        );
    end

    sbc_contact #(.COORD_BITS(COORD_BITS)) u_contact (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fwd    (st_fwd[ROOT_BITS]),
        .in_ready  (st_ready[ROOT_BITS]),
        .root_in   (st_root[ROOT_BITS]),
        .ssq_in    (st_ssq[ROOT_BITS]),
        .side_in   (st_side[ROOT_BITS]),
        .out_fwd   (out_fwd),
        .out_ready (m_tready),
        .hit_out   (hit),
        .nrm_out   (nrm),
        .sp_out    (sp),
        .bp_out    (bp)
    );

    // pack the result word
    assign m_tvalid   = out_fwd.valid;
    assign m_tuser[0] = hit;
    assign m_tdata    = OUT_W'({bp[2], bp[1], bp[0], sp[2], sp[1], sp[0],
                                nrm[2], nrm[1], nrm[0]});

endmodule

// File: design/sbc_checker.sv
module sbc_checker #(
    parameter int COORD_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [((6*COORD_BITS+54+7)/8)*8-1:0]   m_tdata,
    input  logic [0:0]                             m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // a miss carries an all-zero word
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with nonzero fields");

    // normal x stays within unit range
    a_norm_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[17:0]) <= 18'sd65536 &&
                     $signed(m_tdata[17:0]) >= -18'sd65536)
        else $error("normal x out of range");

    // no result word right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid result after reset");

endmodule

bind sphere_box_contact_top sbc_checker #(.COORD_BITS(COORD_BITS)) u_sbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CB = 32;

    // One sphere/box pair as it enters the block
    typedef struct {
        logic signed [CB-1:0] c[3];
        logic        [CB-2:0] r;
        logic signed [CB-1:0] b[3];
        logic        [CB-2:0] h[3];
    } shape_pair_t;

    // One contact word as it leaves the block
    typedef struct {
        bit                   hit;
        logic signed [17:0]   n[3];
        logic signed [CB-1:0] sp[3];
        logic signed [CB-1:0] bp[3];
    } contact_t;

    class contact_board;
        contact_t pending[$];
        int errors, hits, misses, seen;

        task report(string what, int axis, longint got, longint want);
            $display("%0t: %s[%0d] got %0d want %0d", $realtime, what, axis, got, want);
            errors++;
        endtask

        // Largest k in [0, 65536] with (2k-1)^2 * ssq <= 2^34 * w^2
        function automatic longint unit_axis(longint unsigned w, longint unsigned ssq);
            logic [127:0] goal;
            logic [127:0] lhs;
            longint lo, hi, k;
            longint unsigned q;
            goal = 128'(w * w) << 34;
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
                k = (lo + hi + 1) / 2;
                q = 2 * k - 1;
                lhs = 128'(q * q) * 128'(ssq);
                if (lhs <= goal) lo = k;
                else hi = k - 1;
            end
            return lo;
        endfunction

        function automatic contact_t predict_contact(shape_pair_t p);
            contact_t res;
            longint ctr[3], bc[3], cp[3], vec[3], nrm[3], lim_lo, lim_hi, off, pt;
            longint unsigned av[3], w[3], mx, ssq, rad, d;
            logic [127:0] sq;
            bit in_box;
            int len, sh;
            res.hit = 0;
            for (int i = 0; i < 3; i++) begin
                res.n[i] = 0; res.sp[i] = 0; res.bp[i] = 0;
            end
            rad = p.r;
            sq = 0;
            in_box = 1;
            // clamp the center into the box and sum the squared gaps
            for (int i = 0; i < 3; i++) begin
                ctr[i] = p.c[i];
                bc[i] = p.b[i];
                lim_lo = bc[i] - longint'(p.h[i]);
                lim_hi = bc[i] + longint'(p.h[i]);
                cp[i] = ctr[i] < lim_lo ? lim_lo : (ctr[i] > lim_hi ? lim_hi : ctr[i]);
                if (cp[i] != ctr[i]) in_box = 0;
                d = ctr[i] > cp[i] ? ctr[i] - cp[i] : cp[i] - ctr[i];
                sq += 128'(d) * 128'(d);
            end
            if (sq > 128'(rad) * 128'(rad)) return res;
            // reduce the direction to 24 bits and normalize
            mx = 0;
            for (int i = 0; i < 3; i++) begin
                vec[i] = in_box ? ctr[i] - bc[i] : ctr[i] - cp[i];
                av[i] = vec[i] < 0 ? -vec[i] : vec[i];
                if (av[i] > mx) mx = av[i];
            end
            len = 0;
            while (len < 63 && (mx >> len) != 0) len++;
            sh = len > 24 ? len - 24 : 0;
            ssq = 0;
            for (int i = 0; i < 3; i++) begin
                w[i] = av[i] >> sh;
                ssq += w[i] * w[i];
            end
            res.hit = 1;
            for (int i = 0; i < 3; i++) begin
                nrm[i] = ssq == 0 ? 0 : unit_axis(w[i], ssq);
                off = longint'((longint'(nrm[i]) * longint'(rad) + 32768) >>> 16);
                if (vec[i] < 0) begin
                    nrm[i] = -nrm[i];
                    off = -off;
                end
                pt = ctr[i] - off;
                if (pt > 64'sd2147483647) pt = 64'sd2147483647;
                if (pt < -64'sd2147483648) pt = -64'sd2147483648;
                res.n[i] = nrm[i][17:0];
                res.sp[i] = pt[CB-1:0];
                res.bp[i] = cp[i][CB-1:0];
            end
            return res;
        endfunction

        function void note_pair(shape_pair_t p);
            pending = {pending, predict_contact(p)};
        endfunction

        task check_contact(contact_t got);
            contact_t want;
            seen++;
            if (pending.size() == 0) begin
                $display("%0t: contact word with nothing outstanding", $realtime);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.hit) hits++;
            else misses++;
            if (got.hit !== want.hit) report("hit", 0, got.hit, want.hit);
            for (int i = 0; i < 3; i++) begin
                if (got.n[i] !== want.n[i]) report("normal", i, got.n[i], want.n[i]);
                if (got.sp[i] !== want.sp[i]) report("sphere_point", i, got.sp[i], want.sp[i]);
                if (got.bp[i] !== want.bp[i]) report("box_point", i, got.bp[i], want.bp[i]);
            end
        endtask
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [319:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [247:0]  m_tdata;
    logic [0:0]    m_tuser;

    contact_board board = new();
    bit           burst_mode;
    int           sent;

    sphere_box_contact_top #(.COORD_BITS(CB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("sphere_box_contact_top: mismatch");
        $finish;
    end

    // Mostly short gaps, a few long ones, none in burst stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [319:0] pack_pair(shape_pair_t p);
        return {4'b0, p.h[2], p.h[1], p.h[0], p.b[2], p.b[1], p.b[0], p.r,
                p.c[2], p.c[1], p.c[0]};
    endfunction

    function automatic logic signed [CB-1:0] rand_coord(int shift);
        logic signed [CB-1:0] v;
        v = $urandom;
        return v >>> shift;
    endfunction

    // Random pair: raw bits, near contact, or center inside the box
    function automatic shape_pair_t random_pair();
        shape_pair_t p;
        int kind, sc;
        kind = $urandom_range(0, 9);
        sc = $urandom_range(0, 28);
        for (int i = 0; i < 3; i++) begin
            if (kind == 0) begin
                p.b[i] = $urandom;
                p.c[i] = $urandom;
                p.h[i] = 31'($urandom);
            end else begin
                p.b[i] = rand_coord($urandom_range(0, 16));
                p.h[i] = 31'($urandom) >> ($urandom_range(0, 3) + sc);
                if (kind < 4)
                    p.c[i] = p.b[i] + ($signed(p.h[i]) >>> 1) - rand_coord(sc + 1);
                else
                    p.c[i] = p.b[i] + (($urandom_range(0, 1) ? 1 : -1) * $signed(p.h[i]))
                             + rand_coord(sc + $urandom_range(0, 4));
            end
        end
        p.r = kind == 0 ? 31'($urandom) : 31'($urandom) >> (sc + $urandom_range(0, 2));
        return p;
    endfunction

    function automatic shape_pair_t mk_pair(longint cx, longint cy, longint cz, longint r,
                                            longint bx, longint by, longint bz,
                                            longint hx, longint hy, longint hz);
        shape_pair_t p;
        p.c[0] = CB'(cx); p.c[1] = CB'(cy); p.c[2] = CB'(cz); p.r = (CB-1)'(r);
        p.b[0] = CB'(bx); p.b[1] = CB'(by); p.b[2] = CB'(bz);
        p.h[0] = (CB-1)'(hx); p.h[1] = (CB-1)'(hy); p.h[2] = (CB-1)'(hz);
        return p;
    endfunction

    // Hold one word until accepted, then idle for a random gap, if one is picked
    task send_pair(shape_pair_t p);
        int gap;
        s_tdata <= pack_pair(p);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_pair(p);
        sent++;
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Check every accepted contact word
    always @(posedge aclk) begin
        contact_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tuser[0];
            for (int i = 0; i < 3; i++) begin
                got.n[i]  = m_tdata[18*i +: 18];
                got.sp[i] = m_tdata[54 + CB*i +: CB];
                got.bp[i] = m_tdata[54 + 3*CB + CB*i +: CB];
            end
            board.check_contact(got);
        end
    end

    // Stall the result side at random
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = pick_gap();
            m_tready <= stall == 0;
            if (stall > 1) repeat (stall - 1) @(negedge aclk);
        end
    end

    initial begin
        localparam longint MAXC = 64'sd2147483647;
        localparam longint MINC = -64'sd2147483648;
        localparam longint MAXH = 64'sd2147483647;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        burst_mode = 0;
        sent = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed corners
        send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));                // coincident, zero size
        send_pair(mk_pair(5, 5, 5, 65536, 5, 5, 5, 1000, 1000, 1000));   // coincident, inside
        send_pair(mk_pair(100, -300, 20, 1, 0, 0, 0, 1000, 1000, 1000)); // inside, off center
        send_pair(mk_pair(3 << 16, 0, 0, 1 << 16, 0, 0, 0, 2 << 16, 1, 1)); // touching exactly
        send_pair(mk_pair(3 << 16, 0, 0, 65535, 0, 0, 0, 2 << 16, 1, 1));   // just short
        send_pair(mk_pair(MAXC, MAXC, MAXC, MAXH, MINC, MINC, MINC, MAXH, MAXH, MAXH));
        send_pair(mk_pair(MINC, MINC, MINC, MAXH, MAXC, MAXC, MAXC, MAXH, MAXH, MAXH));
        send_pair(mk_pair(MAXC, MINC, MAXC, MAXH, MAXC, MINC, MAXC, 0, 0, 0));
        send_pair(mk_pair(MAXC - 10, 0, 0, MAXH, MAXC, 0, 0, 0, 0, 0));    // saturate high
        send_pair(mk_pair(MINC + 10, 0, 0, MAXH, MINC, 0, 0, 0, 0, 0));    // saturate low
        send_pair(mk_pair(MINC, MAXC, 0, 0, MAXC, MINC, 0, 0, 0, 0));      // far miss
        send_pair(mk_pair(-7, 9, -11, 20, 0, 0, 0, 1, 2, 3));
        send_pair(mk_pair(1 << 30, -(1 << 30), 1 << 29, 1 << 30, 0, 0, 0,
                          1 << 29, 1 << 29, 1 << 29));
        send_pair(mk_pair(-1, -1, -1, MAXH, 0, 0, 0, MAXH, 0, MAXH));

        // Random traffic, with burst stretches and one full drain
        for (int i = 0; i < 940; i++) begin
            if (i % 120 == 0) burst_mode = $urandom_range(0, 2) == 0;
            if (i == 470) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (board.pending.size() != 0);
            end
            send_pair(random_pair());
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for strays
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        $display("Sent %0d sphere/box pairs, checked %0d contact words", sent, board.seen);
        $display("Hits %0d, misses %0d, field errors %0d", board.hits, board.misses,
                 board.errors);
        if (board.errors == 0)
            $display("sphere_box_contact_top: match");
        else
            $display("sphere_box_contact_top: mismatch");
        $finish;
    end

endmodule
